@@ hdl/bvm_pkg.sv @@
// Package for the byte VM instruction executor: opcodes, sizes, status codes and divider types.
// Used by bvm_div and the executor; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bvm_pkg;
  localparam int unsigned VarCountDef   = 256;
  localparam int unsigned StackDepthDef = 8;
  localparam int unsigned LabelCountDef = 256;
  localparam logic [7:0]  BadOpcodeId   = 8'hB1;

  typedef enum logic [4:0] {
    OP_LDLABEL = 5'd0,  OP_ASSIGN = 5'd1,  OP_MOVE  = 5'd2,  OP_ADD   = 5'd3,
    OP_SUB     = 5'd4,  OP_MUL    = 5'd5,  OP_DIV   = 5'd6,  OP_INCR  = 5'd7,
    OP_DECR    = 5'd8,  OP_INV    = 5'd9,  OP_TOB   = 5'd10, OP_CMP   = 5'd11,
    OP_HIGH    = 5'd12, OP_LOW    = 5'd13, OP_LABEL = 5'd14, OP_JUMP  = 5'd15,
    OP_CJUMP   = 5'd16, OP_RET    = 5'd17, OP_DEBUG = 5'd18, OP_ERROR = 5'd19,
    OP_SETFUNC = 5'd20, OP_EXIT   = 5'd21, OP_BAD   = 5'd22, OP_START = 5'd23
  } op_e;

  typedef enum logic [1:0] {
    ST_CONT = 2'd0, ST_EXIT = 2'd1, ST_BAD = 2'd2, ST_USER = 2'd3
  } status_e;

  // Division request to the serial divider.
  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ hdl/bvm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module bvm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/bvm_div.sv @@
// Restoring divider, one quotient bit per cycle; divide by zero gives 255.
// Uses bvm_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none
module bvm_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bvm_pkg::div_req_t req_i,
  output bvm_pkg::div_rsp_t      rsp_o
);
  import bvm_pkg::*;

  logic [7:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [3:0] cnt_q, cnt_d;
  logic       busy_q, busy_d, done_q, done_d;
  logic [8:0] trial;
  logic [8:0] shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[7]};
    trial   = shifted - {1'b0, dvs_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = 4'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (dvs_q == 8'd0) begin
        quo_d  = 8'hFF;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (!trial[8]) begin
          rem_d = trial[7:0];
          quo_d = {quo_q[6:0], 1'b1};
        end else begin
          rem_d = shifted[7:0];
          quo_d = {quo_q[6:0], 1'b0};
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

@@ hdl/byte_vm_instruction_executor.sv @@
// Executes one decoded bytecode instruction per item. An item passes through first
// operand read, second operand read, write back and output load before the block
// returns to idle, and no new item is taken until then. Jump and compare-jump add a
// label memory read, and a divide waits in the serial divider until it is done. A
// result still waiting on the output holds the next item only at its output load.
// After reset a clearing pass zeroes the variable memory, and no item is taken until
// it ends.
// Depends on bvm_pkg, bvm_ram and bvm_div.
`timescale 1ns / 1ps
`default_nettype none
module byte_vm_instruction_executor #(
  parameter int unsigned VAR_COUNT   = bvm_pkg::VarCountDef,
  parameter int unsigned STACK_DEPTH = bvm_pkg::StackDepthDef,
  parameter int unsigned LABEL_COUNT = bvm_pkg::LabelCountDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // action[4:0], first_is_var[5], first_operand[13:6], second_is_var[14],
  // second_operand[22:15], third_is_var[23], third_operand[31:24],
  // call_flag[32], position[48:33], zero fill to 56
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], redirect[2], new_position[18:3], debug_valid[19],
  // debug_value[27:20], error_code[35:28], user_function[43:36], zero fill to 48
  output logic [47:0]      m_axis_tdata
);
  import bvm_pkg::*;

  localparam int unsigned VW = $clog2(VAR_COUNT);
  localparam int unsigned LW = $clog2(LABEL_COUNT);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RDA, S_RDB, S_LBL, S_DIV, S_WB, S_OUT
  } state_e;

  state_e      state_q;
  logic [VW:0] clr_q;
  logic [48:0] ins_q;
  logic [7:0]  a_q, b_q;
  logic [15:0] stk_q [STACK_DEPTH];
  logic [7:0]  func_q, err_q;
  logic [47:0] res_q;
  logic [47:0] out_q;
  logic        ovld_q;

  // Decoded fields of the held item.
  op_e        op;
  logic       f_var, s_var, t_var, call;
  logic [7:0] f_op, s_op, t_op;
  logic [15:0] pos;
  assign op    = op_e'(ins_q[4:0]);
  assign f_var = ins_q[5];
  assign f_op  = ins_q[13:6];
  assign s_var = ins_q[14];
  assign s_op  = ins_q[22:15];
  assign t_var = ins_q[23];
  assign t_op  = ins_q[31:24];
  assign call  = ins_q[32];
  assign pos   = ins_q[48:33];

  // Variable memory.
  logic          v_we;
  logic [VW-1:0] v_wa, v_ra;
  logic [7:0]    v_wd, v_rd;
  bvm_ram #(.Width(8), .Depth(VAR_COUNT)) u_var (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd),
    .raddr_i(v_ra), .rdata_o(v_rd)
  );

  // Label memory.
  logic          l_we;
  logic [LW-1:0] l_ra;
  logic [15:0]   l_rd;
  bvm_ram #(.Width(16), .Depth(LABEL_COUNT)) u_lbl (
    .clk_i, .we_i(l_we), .waddr_i(f_op[LW-1:0]), .wdata_i(pos),
    .raddr_i(l_ra), .rdata_o(l_rd)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  bvm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  function automatic logic in_var(input logic [7:0] idx);
    in_var = ({8'd0, idx} < 16'(VAR_COUNT));
  endfunction

  // Operand values: a variable read is the memory data; out-of-range reads 0.
  logic [7:0] a_src, b_src, t_src, a_val, b_val;
  assign a_src = f_var ? (in_var(f_op) ? v_rd : 8'd0) : f_op;
  assign b_src = s_var ? (in_var(s_op) ? v_rd : 8'd0) : s_op;
  assign t_src = t_var ? (in_var(t_op) ? v_rd : 8'd0) : t_op;
  assign a_val = a_q;
  assign b_val = b_q;

  logic unary, movep;
  assign unary = (op == OP_INCR) || (op == OP_DECR) || (op == OP_INV) || (op == OP_TOB);
  assign movep = (op == OP_MOVE);

  // Write-back value and target.
  logic [15:0] prod;
  logic [7:0]  wval;
  logic [7:0]  widx;
  logic        wen;
  assign prod = a_val * b_val;
  always_comb begin
    wval = 8'd0;
    widx = t_op;
    wen  = 1'b1;
    case (op)
      OP_ASSIGN: begin wval = s_op; widx = f_op; end
      OP_MOVE:   begin wval = b_val; widx = f_op; end
      OP_ADD:    wval = a_val + b_val;
      OP_SUB:    wval = a_val - b_val;
      OP_MUL:    wval = prod[7:0];
      OP_DIV:    wval = drsp.quotient;
      OP_CMP:    wval = {7'd0, a_val == b_val};
      OP_HIGH:   wval = {7'd0, a_val > b_val};
      OP_LOW:    wval = {7'd0, a_val < b_val};
      OP_INCR:   begin wval = a_val + 8'd1; widx = f_op; end
      OP_DECR:   begin wval = a_val - 8'd1; widx = f_op; end
      OP_INV:    begin wval = {7'd0, a_val == 8'd0}; widx = f_op; end
      OP_TOB:    begin wval = {7'd0, a_val != 8'd0}; widx = f_op; end
      default:   wen = 1'b0;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    v_we = 1'b0;
    v_wa = widx[VW-1:0];
    v_wd = wval;
    v_ra = f_op[VW-1:0];
    l_we = 1'b0;
    l_ra = a_q[LW-1:0];
    dreq = '{start: 1'b0, dividend: a_q, divisor: b_q};
    case (state_q)
      S_CLEAR: begin
        v_we = 1'b1;
        v_wa = clr_q[VW-1:0];
        v_wd = 8'd0;
      end
      // The first operand is read straight from the incoming item.
      S_IDLE: v_ra = s_axis_tdata[6 +: VW];
      S_RDA: v_ra = movep ? s_op[VW-1:0] : s_op[VW-1:0];
      S_RDB: v_ra = t_op[VW-1:0];
      S_LBL: l_ra = (op == OP_CJUMP) ? t_src[LW-1:0] : a_q[LW-1:0];
      S_WB: begin
        v_we = wen && in_var(widx);
        l_we = ((op == OP_LDLABEL) || (op == OP_LABEL)) &&
               ({8'd0, f_op} < 16'(LABEL_COUNT));
      end
      default: ;
    endcase
    if (state_q == S_RDB && op == OP_DIV) begin
      dreq.start = 1'b1;
      dreq.divisor = b_src;
    end
  end

  // Sequence: IDLE latches item and reads first operand address; RDA takes
  // a and reads second; RDB takes b and reads third; LBL takes the label
  // operand and reads the label.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ins_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      res_q   <= '0;
      out_q   <= '0;
      ovld_q  <= 1'b0;
      func_q  <= '0;
      err_q   <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (VW+1)'(VAR_COUNT - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          ins_q   <= s_axis_tdata[48:0];
          state_q <= S_RDA;
        end
        S_RDA: begin
          a_q     <= (unary) ? (in_var(f_op) ? v_rd : 8'd0) : a_src;
          state_q <= S_RDB;
        end
        S_RDB: begin
          // Move always reads its source from the variable file.
          b_q <= movep ? (in_var(s_op) ? v_rd : 8'd0) : b_src;
          if (op == OP_JUMP) state_q <= S_LBL;
          else if (op == OP_CJUMP) begin
            state_q <= S_LBL;
            a_q     <= (a_q == b_src) ? 8'd1 : 8'd0;
          end else if (op == OP_DIV) state_q <= S_DIV;
          else state_q <= S_WB;
        end
        S_LBL: begin
          if (op == OP_CJUMP) b_q <= t_src;
          state_q <= S_WB;
        end
        S_DIV: if (drsp.done) state_q <= S_WB;
        S_WB: begin
          state_q <= S_OUT;
        end
        S_OUT: if (!ovld_q || m_axis_tready) begin
          out_q   <= res_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase

      if (state_q == S_WB) begin
        logic [1:0]  st;
        logic        rd;
        logic [15:0] np;
        logic        dv;
        logic [7:0]  dval, er, fn;
        st = ST_CONT; rd = 1'b0; np = '0; dv = 1'b0; dval = '0;
        er = err_q; fn = func_q;
        case (op)
          OP_LDLABEL, OP_ASSIGN, OP_MOVE, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
          OP_INCR, OP_DECR, OP_INV, OP_TOB, OP_CMP, OP_HIGH, OP_LOW,
          OP_LABEL: ;
          OP_JUMP: begin
            rd = 1'b1;
            np = ({8'd0, a_q} < 16'(LABEL_COUNT)) ? l_rd : 16'd0;
          end
          OP_CJUMP: if (a_q[0]) begin
            rd = 1'b1;
            np = ({8'd0, b_q} < 16'(LABEL_COUNT)) ? l_rd : 16'd0;
          end
          OP_RET: begin
            rd = 1'b1;
            np = stk_q[0];
            for (int i = 1; i < STACK_DEPTH; i++) stk_q[i-1] <= stk_q[i];
          end
          OP_DEBUG:   begin dv = 1'b1; dval = a_q; end
          OP_ERROR:   begin er = a_q; st = ST_USER; end
          OP_SETFUNC: fn = a_q;
          OP_EXIT:    st = ST_EXIT;
          OP_START:   for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= '0;
          default:    begin er = BadOpcodeId; st = ST_BAD; end
        endcase
        if ((op == OP_JUMP || op == OP_CJUMP) && call) begin
          for (int i = STACK_DEPTH - 1; i > 0; i--) stk_q[i] <= stk_q[i-1];
          stk_q[0] <= pos;
        end
        err_q  <= er;
        func_q <= fn;
        res_q  <= {4'd0, fn, er, dval, dv, np, rd, st};
      end

      if (state_q == S_OUT && (!ovld_q || m_axis_tready)) ovld_q <= 1'b1;
      else if (m_axis_tready) ovld_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire
